[hdl/mmp_pkg.sv]
// Shared types, constants and helpers for the modular matrix power block.
`timescale 1ns / 1ps

package mmp_pkg;

  localparam int MAX_DIM     = 8;
  localparam int EXP_BITS    = 40;
  localparam int CELLS       = MAX_DIM * MAX_DIM;
  localparam int IDX_W       = $clog2(MAX_DIM);
  localparam int DIM_W       = $clog2(MAX_DIM + 1);
  localparam int CELL_W      = $clog2(CELLS);
  localparam int CNT_W       = $clog2(CELLS + 1);
  localparam int BANKS       = 3;
  localparam int BANK_W      = 2;
  localparam int ADDR_W      = BANK_W + CELL_W;
  localparam int MEM_DEPTH   = BANKS * CELLS;
  localparam int VAL_W       = 10;
  localparam int P_W         = 2 * VAL_W;
  localparam int MOD_VAL     = 1000;
  localparam int RECIP_SHIFT = 30;
  localparam int RECIP       = (1 << RECIP_SHIFT) / MOD_VAL;
  localparam int RECIP_W     = 21;
  localparam int PROD_W      = P_W + RECIP_W;

  localparam logic [0:0] REG_DIMENSION = 1'b0;
  localparam logic [0:0] REG_EXPONENT  = 1'b1;

  localparam logic [BANK_W-1:0] BANK_BASE_RST = 2'd0;
  localparam logic [BANK_W-1:0] BANK_RES_RST  = 2'd1;
  localparam logic [BANK_W-1:0] BANK_SCR_RST  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DRAIN,
    ST_OUT
  } mmp_state_t;

  typedef enum logic {
    MUL_RES,
    MUL_SQR
  } mmp_mul_t;

  typedef struct packed {
    logic              valid;
    logic              first;
    logic              last;
    logic [ADDR_W-1:0] waddr;
    logic              a_force;
    logic              a_val;
    logic              b_force;
  } mmp_op_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  data;
  } mmp_wr_t;

  function automatic logic [CELL_W-1:0] flat_idx(input logic [IDX_W-1:0] r,
                                                 input logic [IDX_W-1:0] c,
                                                 input logic [DIM_W-1:0] d);
    logic [IDX_W+DIM_W-1:0] prod;
    prod = (IDX_W + DIM_W)'(r) * (IDX_W + DIM_W)'(d);
    return CELL_W'(prod + (IDX_W + DIM_W)'(c));
  endfunction

endpackage

[hdl/mmp_mem.sv]
// Three-bank matrix memory with one write port and two registered read ports.
`timescale 1ns / 1ps

module mmp_mem (
  input  logic                                  clk,
  input  mmp_pkg::mmp_wr_t                      wr,
  input  logic [mmp_pkg::ADDR_W-1:0]            rd_addr_a,
  input  logic [mmp_pkg::ADDR_W-1:0]            rd_addr_b,
  output logic [mmp_pkg::VAL_W-1:0]             rd_data_a,
  output logic [mmp_pkg::VAL_W-1:0]             rd_data_b
);

  logic [mmp_pkg::VAL_W-1:0] ram_r [0:mmp_pkg::MEM_DEPTH-1];
  logic [mmp_pkg::VAL_W-1:0] rda_r;
  logic [mmp_pkg::VAL_W-1:0] rdb_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      ram_r[wr.addr] <= wr.data;
    end
    rda_r <= ram_r[rd_addr_a];
    rdb_r <= ram_r[rd_addr_b];
  end

  assign rd_data_a = rda_r;
  assign rd_data_b = rdb_r;

endmodule

[hdl/mmp_mac.sv]
// Pipelined multiply, modulo 1000 reduction and accumulation of one product entry.
`timescale 1ns / 1ps

module mmp_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mmp_pkg::mmp_op_t              op,
  input  logic [mmp_pkg::VAL_W-1:0]     rd_data_a,
  input  logic [mmp_pkg::VAL_W-1:0]     rd_data_b,
  output mmp_pkg::mmp_wr_t              wr,
  output logic                          busy
);

  localparam logic [mmp_pkg::RECIP_W-1:0] RECIP_C = mmp_pkg::RECIP_W'(mmp_pkg::RECIP);
  localparam logic [mmp_pkg::P_W-1:0]     MOD_P   = mmp_pkg::P_W'(mmp_pkg::MOD_VAL);
  localparam logic [mmp_pkg::VAL_W:0]     MOD_S   = (mmp_pkg::VAL_W + 1)'(mmp_pkg::MOD_VAL);

  mmp_pkg::mmp_op_t op2_r, op3_r, op4_r;
  mmp_pkg::mmp_wr_t wr_r, wr_nxt;
  logic [mmp_pkg::VAL_W-1:0]  a_val, b_val;
  logic [mmp_pkg::P_W-1:0]    p2_r, p2_nxt, p3_r;
  logic [mmp_pkg::PROD_W-1:0] qprod;
  logic [mmp_pkg::VAL_W-1:0]  q3_r, q3_nxt;
  logic [mmp_pkg::P_W-1:0]    rem;
  logic [mmp_pkg::VAL_W:0]    rem_s;
  logic [mmp_pkg::VAL_W-1:0]  r4_r, r4_nxt;
  logic [mmp_pkg::VAL_W-1:0]  acc_r, acc_nxt;
  logic [mmp_pkg::VAL_W:0]    sum;

  always_comb begin
    a_val  = op.a_force ? mmp_pkg::VAL_W'(op.a_val) : rd_data_a;
    b_val  = op.b_force ? '0 : rd_data_b;
    p2_nxt = mmp_pkg::P_W'(a_val) * mmp_pkg::P_W'(b_val);
  end

  always_comb begin
    qprod  = mmp_pkg::PROD_W'(p2_r) * mmp_pkg::PROD_W'(RECIP_C);
    q3_nxt = qprod[mmp_pkg::RECIP_SHIFT +: mmp_pkg::VAL_W];
  end

  always_comb begin
    rem   = p3_r - mmp_pkg::P_W'(q3_r) * MOD_P;
    rem_s = rem[mmp_pkg::VAL_W:0];
    if (rem_s >= MOD_S) begin
      rem_s = rem_s - MOD_S;
    end
    r4_nxt = rem_s[mmp_pkg::VAL_W-1:0];
  end

  always_comb begin
    sum = (op4_r.first ? '0 : {1'b0, acc_r}) + {1'b0, r4_r};
    if (sum >= MOD_S) begin
      sum = sum - MOD_S;
    end
    acc_nxt     = sum[mmp_pkg::VAL_W-1:0];
    wr_nxt.we   = op4_r.valid && op4_r.last;
    wr_nxt.addr = op4_r.waddr;
    wr_nxt.data = acc_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op2_r <= '0;
      op3_r <= '0;
      op4_r <= '0;
      wr_r  <= '0;
    end else begin
      op2_r <= op;
      op3_r <= op2_r;
      op4_r <= op3_r;
      wr_r  <= wr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p2_r <= p2_nxt;
    p3_r <= p2_r;
    q3_r <= q3_nxt;
    r4_r <= r4_nxt;
    if (op4_r.valid) begin
      acc_r <= acc_nxt;
    end
  end

  assign wr   = wr_r;
  assign busy = op2_r.valid || op3_r.valid || op4_r.valid || wr_r.we;

endmodule

[hdl/modular_matrix_power.sv]
// Top level: load, square-and-multiply sequencer and result output of the matrix power block.
//
// Elements load at one per cycle while busy is low; the item with in_last_element set
// starts the job and busy rises. Each matrix product of dimension d runs one multiply-add
// per cycle, as bounded by the two read ports of the matrix memory; the multiply pipeline
// then drains before the banks swap and the next step is picked. An exponent with bit
// length L and popcount P needs P result multiplies and L-1 squarings. Results then leave
// at one entry per cycle, each valid for exactly the one cycle that out_valid is high;
// the receiver cannot stall them and must take every one.
`timescale 1ns / 1ps

module modular_matrix_power (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [9:0]  in_element,
  input  logic        in_last_element,
  output logic        out_valid,
  output logic [9:0]  out_value,
  output logic [2:0]  out_row,
  output logic [2:0]  out_column,
  output logic        out_last_result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [39:0] cfg_data
);

  localparam logic [mmp_pkg::VAL_W-1:0] MOD_V = mmp_pkg::VAL_W'(mmp_pkg::MOD_VAL);

  mmp_pkg::mmp_state_t state_r, state_nxt;
  mmp_pkg::mmp_mul_t   kind_r, kind_nxt;
  logic [mmp_pkg::DIM_W-1:0]    dim_r;
  logic [mmp_pkg::EXP_BITS-1:0] exp_cfg_r;
  logic [mmp_pkg::DIM_W-1:0]    d_r, d_nxt, d_sat;
  logic [mmp_pkg::EXP_BITS-1:0] exp_left_r, exp_left_nxt;
  logic [mmp_pkg::CNT_W-1:0]    load_cnt_r, load_cnt_nxt;
  logic [mmp_pkg::IDX_W-1:0]    i_r, i_nxt, j_r, j_nxt, k_r, k_nxt, dm1;
  logic [mmp_pkg::BANK_W-1:0]   base_ptr_r, base_ptr_nxt;
  logic [mmp_pkg::BANK_W-1:0]   res_ptr_r, res_ptr_nxt;
  logic [mmp_pkg::BANK_W-1:0]   scr_ptr_r, scr_ptr_nxt;
  logic res_ident_r, res_ident_nxt;
  logic base_raw_r, base_raw_nxt;
  logic bit_done_r, bit_done_nxt;
  mmp_pkg::mmp_op_t op_r, op_nxt;
  logic opv_r, opv_nxt, olast_r, olast_nxt, oforce_r, oforce_nxt, oval_r, oval_nxt;
  logic [mmp_pkg::IDX_W-1:0] orow_r, orow_nxt, ocol_r, ocol_nxt;

  logic accept, end_i, end_j, end_k, mac_busy;
  logic [mmp_pkg::CELL_W-1:0] idx_ij, idx_jk, idx_ik;
  logic [mmp_pkg::VAL_W-1:0]  elem_red, rd_data_a, rd_data_b;
  logic [mmp_pkg::ADDR_W-1:0] rd_addr_a, rd_addr_b;
  mmp_pkg::mmp_wr_t load_wr, mac_wr, mem_wr;

  assign busy      = (state_r != mmp_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign dm1       = mmp_pkg::IDX_W'(d_r - mmp_pkg::DIM_W'(1));
  assign end_i     = (i_r == dm1);
  assign end_j     = (j_r == dm1);
  assign end_k     = (k_r == dm1);
  assign idx_ij    = mmp_pkg::flat_idx(i_r, j_r, d_r);
  assign idx_jk    = mmp_pkg::flat_idx(j_r, k_r, d_r);
  assign idx_ik    = mmp_pkg::flat_idx(i_r, k_r, d_r);
  assign elem_red  = (in_element >= MOD_V) ? in_element - MOD_V : in_element;

  always_comb begin
    if (dim_r == '0) begin
      d_sat = mmp_pkg::DIM_W'(1);
    end else if (dim_r > mmp_pkg::DIM_W'(mmp_pkg::MAX_DIM)) begin
      d_sat = mmp_pkg::DIM_W'(mmp_pkg::MAX_DIM);
    end else begin
      d_sat = dim_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r     <= mmp_pkg::DIM_W'(2);
      exp_cfg_r <= mmp_pkg::EXP_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mmp_pkg::REG_DIMENSION: dim_r     <= cfg_data[mmp_pkg::DIM_W-1:0];
        mmp_pkg::REG_EXPONENT:  exp_cfg_r <= cfg_data[mmp_pkg::EXP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mmp_pkg::ST_IDLE: begin
        if (accept && in_last_element) begin
          state_nxt = mmp_pkg::ST_CHECK;
        end
      end
      mmp_pkg::ST_CHECK: begin
        if (exp_left_r == '0) begin
          state_nxt = mmp_pkg::ST_OUT;
        end else if ((exp_left_r[0] && !bit_done_r) ||
                     (exp_left_r[mmp_pkg::EXP_BITS-1:1] != '0)) begin
          state_nxt = mmp_pkg::ST_MUL;
        end
      end
      mmp_pkg::ST_MUL: begin
        if (end_i && end_j && end_k) begin
          state_nxt = mmp_pkg::ST_DRAIN;
        end
      end
      mmp_pkg::ST_DRAIN: begin
        if (!op_r.valid && !mac_busy) begin
          state_nxt = mmp_pkg::ST_CHECK;
        end
      end
      mmp_pkg::ST_OUT: begin
        if (end_i && end_k) begin
          state_nxt = mmp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mmp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    kind_nxt      = kind_r;
    d_nxt         = d_r;
    exp_left_nxt  = exp_left_r;
    load_cnt_nxt  = load_cnt_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    base_ptr_nxt  = base_ptr_r;
    res_ptr_nxt   = res_ptr_r;
    scr_ptr_nxt   = scr_ptr_r;
    res_ident_nxt = res_ident_r;
    base_raw_nxt  = base_raw_r;
    bit_done_nxt  = bit_done_r;
    op_nxt        = '0;
    opv_nxt       = 1'b0;
    orow_nxt      = i_r;
    ocol_nxt      = k_r;
    olast_nxt     = end_i && end_k;
    oforce_nxt    = res_ident_r;
    oval_nxt      = (i_r == k_r);
    load_wr.we    = 1'b0;
    load_wr.addr  = {base_ptr_r, load_cnt_r[mmp_pkg::CELL_W-1:0]};
    load_wr.data  = elem_red;
    rd_addr_a     = {(kind_r == mmp_pkg::MUL_RES) ? res_ptr_r : base_ptr_r, idx_ij};
    rd_addr_b     = {base_ptr_r, idx_jk};
    case (state_r)
      mmp_pkg::ST_IDLE: begin
        if (accept) begin
          if (load_cnt_r < mmp_pkg::CNT_W'(mmp_pkg::CELLS)) begin
            load_wr.we   = 1'b1;
            load_cnt_nxt = load_cnt_r + mmp_pkg::CNT_W'(1);
          end
          if (in_last_element) begin
            d_nxt         = d_sat;
            exp_left_nxt  = exp_cfg_r;
            res_ident_nxt = 1'b1;
            base_raw_nxt  = 1'b1;
            bit_done_nxt  = 1'b0;
            i_nxt         = '0;
            j_nxt         = '0;
            k_nxt         = '0;
          end
        end
      end
      mmp_pkg::ST_CHECK: begin
        i_nxt = '0;
        j_nxt = '0;
        k_nxt = '0;
        if (exp_left_r != '0) begin
          if (exp_left_r[0] && !bit_done_r) begin
            kind_nxt = mmp_pkg::MUL_RES;
          end else if (exp_left_r[mmp_pkg::EXP_BITS-1:1] != '0) begin
            kind_nxt = mmp_pkg::MUL_SQR;
          end else begin
            exp_left_nxt = exp_left_r >> 1;
            bit_done_nxt = 1'b0;
          end
        end
      end
      mmp_pkg::ST_MUL: begin
        op_nxt.valid = 1'b1;
        op_nxt.first = (j_r == '0);
        op_nxt.last  = end_j;
        op_nxt.waddr = {scr_ptr_r, idx_ik};
        if (kind_r == mmp_pkg::MUL_RES) begin
          op_nxt.a_force = res_ident_r;
          op_nxt.a_val   = (i_r == j_r);
        end else begin
          op_nxt.a_force = base_raw_r && (mmp_pkg::CNT_W'(idx_ij) >= load_cnt_r);
          op_nxt.a_val   = 1'b0;
        end
        op_nxt.b_force = base_raw_r && (mmp_pkg::CNT_W'(idx_jk) >= load_cnt_r);
        if (end_j) begin
          j_nxt = '0;
          if (end_k) begin
            k_nxt = '0;
            i_nxt = end_i ? '0 : i_r + mmp_pkg::IDX_W'(1);
          end else begin
            k_nxt = k_r + mmp_pkg::IDX_W'(1);
          end
        end else begin
          j_nxt = j_r + mmp_pkg::IDX_W'(1);
        end
      end
      mmp_pkg::ST_DRAIN: begin
        if (!op_r.valid && !mac_busy) begin
          if (kind_r == mmp_pkg::MUL_RES) begin
            res_ptr_nxt   = scr_ptr_r;
            scr_ptr_nxt   = res_ptr_r;
            res_ident_nxt = 1'b0;
            bit_done_nxt  = 1'b1;
          end else begin
            base_ptr_nxt = scr_ptr_r;
            scr_ptr_nxt  = base_ptr_r;
            base_raw_nxt = 1'b0;
            exp_left_nxt = exp_left_r >> 1;
            bit_done_nxt = 1'b0;
          end
        end
      end
      mmp_pkg::ST_OUT: begin
        rd_addr_a = {res_ptr_r, idx_ik};
        opv_nxt   = 1'b1;
        if (end_k) begin
          k_nxt = '0;
          i_nxt = end_i ? '0 : i_r + mmp_pkg::IDX_W'(1);
        end else begin
          k_nxt = k_r + mmp_pkg::IDX_W'(1);
        end
        if (end_i && end_k) begin
          load_cnt_nxt = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mmp_pkg::ST_IDLE;
      kind_r      <= mmp_pkg::MUL_RES;
      d_r         <= mmp_pkg::DIM_W'(1);
      exp_left_r  <= '0;
      load_cnt_r  <= '0;
      i_r         <= '0;
      j_r         <= '0;
      k_r         <= '0;
      base_ptr_r  <= mmp_pkg::BANK_BASE_RST;
      res_ptr_r   <= mmp_pkg::BANK_RES_RST;
      scr_ptr_r   <= mmp_pkg::BANK_SCR_RST;
      res_ident_r <= 1'b1;
      base_raw_r  <= 1'b1;
      bit_done_r  <= 1'b0;
      op_r        <= '0;
      opv_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kind_r      <= kind_nxt;
      d_r         <= d_nxt;
      exp_left_r  <= exp_left_nxt;
      load_cnt_r  <= load_cnt_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      k_r         <= k_nxt;
      base_ptr_r  <= base_ptr_nxt;
      res_ptr_r   <= res_ptr_nxt;
      scr_ptr_r   <= scr_ptr_nxt;
      res_ident_r <= res_ident_nxt;
      base_raw_r  <= base_raw_nxt;
      bit_done_r  <= bit_done_nxt;
      op_r        <= op_nxt;
      opv_r       <= opv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    orow_r   <= orow_nxt;
    ocol_r   <= ocol_nxt;
    olast_r  <= olast_nxt;
    oforce_r <= oforce_nxt;
    oval_r   <= oval_nxt;
  end

  assign mem_wr = (state_r == mmp_pkg::ST_IDLE) ? load_wr : mac_wr;

  mmp_mem u_mem (
    .clk       (clk),
    .wr        (mem_wr),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  mmp_mac u_mac (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op_r),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b),
    .wr        (mac_wr),
    .busy      (mac_busy)
  );

  assign out_valid       = opv_r;
  assign out_value       = oforce_r ? mmp_pkg::VAL_W'(oval_r) : rd_data_a;
  assign out_row         = orow_r;
  assign out_column      = ocol_r;
  assign out_last_result = olast_r;

endmodule

[tb/testbench.sv]
// Testbench for modular_matrix_power: directed and random power jobs checked against a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned IDLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 20;

  typedef struct packed {
    logic [9:0] value;
    logic [2:0] row;
    logic [2:0] column;
    logic       last_result;
  } entry_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic [9:0]  in_element = '0;
  logic        in_last_element = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [0:0]  cfg_index = mmp_pkg::REG_DIMENSION;
  logic [39:0] cfg_data = '0;
  logic        busy;
  logic        out_valid;
  logic [9:0]  out_value;
  logic [2:0]  out_row;
  logic [2:0]  out_column;
  logic        out_last_result;
  logic        cfg_ready;

  entry_t      expected_entries[$];
  int unsigned failures = 0;
  int unsigned idle_cycles = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stored_items = 0;

  logic [3:0]  dim_setting = 4'd2;
  logic [39:0] power_setting = 40'd1;
  logic [9:0]  loaded [mmp_pkg::CELLS];
  int unsigned load_fill = 0;
  int unsigned job_dim;
  int unsigned base_m [mmp_pkg::CELLS];
  int unsigned power_m [mmp_pkg::CELLS];
  int unsigned scratch_m [mmp_pkg::CELLS];

  modular_matrix_power dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_element      (in_element),
    .in_last_element (in_last_element),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .out_row         (out_row),
    .out_column      (out_column),
    .out_last_result (out_last_result),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic multiply(input mmp_pkg::mmp_mul_t kind);
    int unsigned i, j, k, lhs;
    for (i = 0; i < job_dim; i++) begin
      for (k = 0; k < job_dim; k++) scratch_m[i * job_dim + k] = 0;
      for (j = 0; j < job_dim; j++) begin
        for (k = 0; k < job_dim; k++) begin
          lhs = (kind == mmp_pkg::MUL_RES) ? power_m[i * job_dim + j]
                                           : base_m[i * job_dim + j];
          scratch_m[i * job_dim + k] =
            (scratch_m[i * job_dim + k] + lhs * base_m[j * job_dim + k]) % mmp_pkg::MOD_VAL;
        end
      end
    end
    for (i = 0; i < job_dim * job_dim; i++) begin
      if (kind == mmp_pkg::MUL_RES) begin
        power_m[i] = scratch_m[i];
      end else begin
        base_m[i] = scratch_m[i];
      end
    end
  endtask

  task automatic absorb_element(input logic [9:0] elem, input logic last);
    int unsigned i, n;
    logic [39:0] bits_left;
    entry_t entry;
    if (load_fill < mmp_pkg::CELLS) begin
      loaded[load_fill] = elem;
      load_fill++;
      stored_items++;
    end
    if (!last) return;
    job_dim = (dim_setting == 0) ? 1 :
              (dim_setting > mmp_pkg::MAX_DIM) ? mmp_pkg::MAX_DIM : dim_setting;
    n = job_dim * job_dim;
    for (i = 0; i < mmp_pkg::CELLS; i++) begin
      base_m[i] = (i < load_fill) ? loaded[i] : 0;
      power_m[i] = (i < n && i / job_dim == i % job_dim) ? 1 : 0;
    end
    bits_left = power_setting;
    while (bits_left != 0) begin
      if (bits_left[0]) multiply(mmp_pkg::MUL_RES);
      multiply(mmp_pkg::MUL_SQR);
      bits_left = bits_left >> 1;
    end
    load_fill = 0;
    for (i = 0; i < n; i++) begin
      entry.value = 10'(power_m[i]);
      entry.row = 3'(i / job_dim);
      entry.column = 3'(i % job_dim);
      entry.last_result = (i == n - 1);
      expected_entries.push_back(entry);
    end
  endtask

  task automatic send_element(input logic [9:0] elem, input logic last);
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < sender_idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_element <= elem;
    in_last_element <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    absorb_element(elem, last);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_entries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [3:0] dim, input logic [39:0] power);
    cfg_valid <= 1'b1;
    cfg_index <= mmp_pkg::REG_DIMENSION;
    cfg_data <= 40'(dim);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dim_setting = dim;
    cfg_index <= mmp_pkg::REG_EXPONENT;
    cfg_data <= power;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    power_setting = power;
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_defaults();
    send_element(10'd1023, 1'b0);
    send_element(10'd0, 1'b0);
    send_element(10'd1000, 1'b0);
    send_element(10'd999, 1'b1);
  endtask

  task automatic test_zero_exponent();
    int unsigned k;
    wait_drained();
    configure(4'd2, 40'd0);
    for (k = 0; k < 4; k++) send_element(10'($urandom_range(0, 1023)), k == 3);
  endtask

  task automatic test_dimension_zero();
    wait_drained();
    configure(4'd0, 40'd7);
    send_element(10'd1023, 1'b1);
  endtask

  task automatic test_short_load_oversize_dim();
    int unsigned k;
    wait_drained();
    configure(4'd15, 40'd3);
    for (k = 0; k < 5; k++) send_element(10'($urandom_range(0, 1023)), k == 4);
  endtask

  task automatic test_max_power();
    int unsigned k;
    wait_drained();
    configure(4'd8, 40'hFF_FFFF_FFFF);
    for (k = 0; k < 10; k++) send_element(10'($urandom_range(0, 1023)), k == 9);
  endtask

  task automatic test_random_jobs(input int unsigned idle_pct, input int unsigned item_goal);
    int unsigned goal_mark, pick, raw_dim, d, n, max_bits, bit_len, count, k;
    logic [63:0] power;
    logic [9:0] elem;
    sender_idle_pct = idle_pct;
    goal_mark = stored_items + item_goal;
    while (stored_items < goal_mark) begin
      pick = $urandom_range(99);
      if (pick < 10) begin
        raw_dim = $urandom_range(1) ? 0 : $urandom_range(9, 15);
      end else if (pick < 60) begin
        raw_dim = $urandom_range(1, 3);
      end else if (pick < 88) begin
        raw_dim = $urandom_range(4, 5);
      end else begin
        raw_dim = $urandom_range(6, 8);
      end
      d = (raw_dim == 0) ? 1 : (raw_dim > mmp_pkg::MAX_DIM) ? mmp_pkg::MAX_DIM : raw_dim;
      n = d * d;
      max_bits = (d <= 3) ? 40 : (d <= 5) ? 16 : 8;
      bit_len = $urandom_range(0, max_bits);
      power = {$urandom, $urandom};
      if (bit_len == 0) begin
        power = 64'd0;
      end else begin
        power = (power & ((64'd1 << bit_len) - 1)) | (64'd1 << (bit_len - 1));
      end
      wait_drained();
      configure(4'(raw_dim), power[39:0]);
      pick = $urandom_range(99);
      if (pick < 70 || (n == 1 && pick < 85)) begin
        count = n;
      end else if (pick < 85) begin
        count = $urandom_range(1, n - 1);
      end else if (pick < 95) begin
        count = $urandom_range(n + 1, n + 8);
      end else begin
        count = $urandom_range(mmp_pkg::CELLS + 1, mmp_pkg::CELLS + 8);
      end
      for (k = 0; k < count; k++) begin
        case ($urandom_range(7))
          0: elem = 10'd0;
          1: elem = 10'd1023;
          2: elem = 10'd999;
          3: elem = 10'd1000;
          default: elem = 10'($urandom_range(0, 1023));
        endcase
        send_element(elem, k == count - 1);
      end
    end
  endtask

  function automatic void compare_field(input string name, input logic [9:0] want,
                                        input logic [9:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      failures++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    entry_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (expected_entries.size() == 0) begin
        $error("value: expected no transaction, actual %0d", out_value);
        failures++;
      end else begin
        want = expected_entries.pop_front();
        compare_field("value", want.value, out_value);
        compare_field("row", 10'(want.row), 10'(out_row));
        compare_field("column", 10'(want.column), 10'(out_column));
        compare_field("last_result", 10'(want.last_result), 10'(out_last_result));
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("modular_matrix_power: mismatch");
      $finish;
    end
  end

  // The result side has no back-pressure, so only the sender idles.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_zero_exponent();
    test_dimension_zero();
    test_short_load_oversize_dim();
    test_max_power();
    test_random_jobs(0, RANDOM_ITEMS);
    test_random_jobs(74, RANDOM_ITEMS);
    test_random_jobs(38, RANDOM_ITEMS);
    wait_drained();
    if (failures == 0) begin
      $display("modular_matrix_power: match");
    end else begin
      $display("modular_matrix_power: mismatch");
    end
    $finish;
  end

endmodule
